@@ design/i2cmrw_pkg.sv @@
package i2cmrw_pkg;

	localparam int SEG_W = 4;
	localparam int OFF_W = 5;
	localparam int TRI_W = 2;

	// segment kinds
	localparam logic [2:0] KIND_START = 3'd0;
	localparam logic [2:0] KIND_SEND  = 3'd1;
	localparam logic [2:0] KIND_RACK  = 3'd2;
	localparam logic [2:0] KIND_RECV  = 3'd3;
	localparam logic [2:0] KIND_SACK  = 3'd4;
	localparam logic [2:0] KIND_STOP  = 3'd5;

	// segment arguments
	localparam logic [1:0] ARG_ADDR_WR = 2'd0;
	localparam logic [1:0] ARG_REG     = 2'd1;
	localparam logic [1:0] ARG_ADDR_RD = 2'd2;
	localparam logic [1:0] ARG_LOW     = 2'd0;
	localparam logic [1:0] ARG_HIGH    = 2'd1;
	localparam logic [1:0] ARG_PEC     = 2'd2;
	localparam logic [1:0] ARG_ACK     = 2'd0;
	localparam logic [1:0] ARG_NACK    = 2'd1;

	localparam logic [SEG_W-1:0] LAST_SEG = 4'd14;
	// offset of the eighth sample inside a receive segment
	localparam logic [OFF_W-1:0] RECV_LAST_SAMPLE = 5'd23;

	localparam logic [6:0] DEV_ADDR_RESET = 7'd90;

	typedef struct packed {
		logic        scl_out;
		logic        sda_out;
		logic        busy_res;
		logic        done_res;
		logic [15:0] read_word;
		logic [7:0]  pec_byte;
		logic        ack_missed;
	} result_t;

	typedef struct packed {
		logic       start_req;
		logic [7:0] reg_addr;
		logic       sda_in;
	} item_t;

	function automatic logic [2:0] seg_kind(input logic [SEG_W-1:0] s);
		logic [2:0] k;
		unique case (s)
			4'd0, 4'd5:        k = KIND_START;
			4'd1, 4'd3, 4'd6:  k = KIND_SEND;
			4'd2, 4'd4, 4'd7:  k = KIND_RACK;
			4'd8, 4'd10, 4'd12: k = KIND_RECV;
			4'd9, 4'd11, 4'd13: k = KIND_SACK;
			default:           k = KIND_STOP;
		endcase
		return k;
	endfunction

	function automatic logic [1:0] seg_arg(input logic [SEG_W-1:0] s);
		logic [1:0] a;
		unique case (s)
			4'd3, 4'd10:  a = ARG_REG;
			4'd6, 4'd12:  a = ARG_ADDR_RD;
			4'd13:        a = ARG_NACK;
			default:      a = ARG_ADDR_WR;
		endcase
		return a;
	endfunction

	function automatic logic [OFF_W-1:0] seg_last_off(input logic [2:0] k);
		logic [OFF_W-1:0] n;
		unique case (k)
			KIND_SEND:          n = 5'd23;
			KIND_RECV:          n = 5'd24;
			KIND_SACK, KIND_STOP: n = 5'd2;
			default:            n = 5'd3;
		endcase
		return n;
	endfunction

endpackage

@@ design/i2cmrw_seq.sv @@
module i2cmrw_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  i2cmrw_pkg::item_t  item,
	input  logic [6:0]         dev_addr,
	output i2cmrw_pkg::result_t res
);
	import i2cmrw_pkg::*;

	logic             active_q, active_n;
	logic [SEG_W-1:0] seg_q, seg_n, seg_c;
	logic [OFF_W-1:0] off_q, off_n, off_c;
	logic [TRI_W-1:0] tri_q, tri_n, tri_c, rp;
	logic [7:0]       shift_q, shift_n, held_q, held_n;
	logic [7:0]       low_q, low_n, high_q, high_n, pec_q, pec_n;
	logic             scl_q, scl_n, sda_q, sda_n, ack_q, ack_n;
	logic             act_c, last, done;
	logic [2:0]       kind;
	logic [1:0]       arg;
	logic [7:0]       tx_byte, rx_byte;

	always_comb begin
		held_n  = held_q;
		ack_n   = ack_q;
		shift_n = shift_q;
		low_n   = low_q;
		high_n  = high_q;
		pec_n   = pec_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		if (!active_q && item.start_req) begin
			act_c  = 1'b1;
			seg_c  = '0;
			off_c  = '0;
			tri_c  = '0;
			held_n = item.reg_addr;
			ack_n  = 1'b0;
		end else begin
			act_c = active_q;
			seg_c = seg_q;
			off_c = off_q;
			tri_c = tri_q;
		end
		kind = seg_kind(seg_c);
		arg  = seg_arg(seg_c);
		// phase of (offset - 1) within a receive bit
		rp = (tri_c == 2'd0) ? 2'd2 : tri_c - 2'd1;
		tx_byte = shift_q;
		if (off_c == '0) begin
			tx_byte = (arg == ARG_REG) ? held_n : {dev_addr, (arg == ARG_ADDR_RD)};
		end
		rx_byte = {shift_q[6:0], item.sda_in};
		if (act_c) begin
			unique case (kind)
				KIND_START: begin
					unique case (off_c[1:0])
						2'd0:    sda_n = 1'b1;
						2'd1:    scl_n = 1'b1;
						2'd2:    sda_n = 1'b0;
						default: scl_n = 1'b0;
					endcase
				end
				KIND_SEND: begin
					if (tri_c == 2'd0) begin
						sda_n   = tx_byte[7];
						shift_n = {tx_byte[6:0], 1'b0};
					end else begin
						scl_n = (tri_c == 2'd1);
					end
				end
				KIND_RACK: begin
					unique case (off_c[1:0])
						2'd0:    sda_n = 1'b1;
						2'd1:    scl_n = 1'b1;
						2'd2:    ack_n = ack_q | item.sda_in;
						default: scl_n = 1'b0;
					endcase
				end
				KIND_RECV: begin
					if (off_c == '0) begin
						sda_n   = 1'b1;
						shift_n = '0;
					end else if (rp == 2'd0) begin
						scl_n = 1'b1;
					end else if (rp == 2'd1) begin
						shift_n = rx_byte;
						if (off_c == RECV_LAST_SAMPLE) begin
							unique case (arg)
								ARG_LOW:  low_n  = rx_byte;
								ARG_HIGH: high_n = rx_byte;
								default:  pec_n  = rx_byte;
							endcase
						end
					end else begin
						scl_n = 1'b0;
					end
				end
				KIND_SACK: begin
					if (off_c == '0) sda_n = (arg == ARG_NACK);
					else scl_n = (off_c == 5'd1);
				end
				default: begin
					if (off_c == '0) sda_n = 1'b0;
					else if (off_c == 5'd1) scl_n = 1'b1;
					else sda_n = 1'b1;
				end
			endcase
		end
		last = (seg_c == LAST_SEG) && (off_c == seg_last_off(kind));
		done = act_c && last;
		active_n = act_c && !last;
		if (off_c == seg_last_off(kind)) begin
			seg_n = seg_c + 4'd1;
			off_n = '0;
			tri_n = '0;
		end else begin
			seg_n = seg_c;
			off_n = off_c + 5'd1;
			tri_n = (tri_c == 2'd2) ? 2'd0 : tri_c + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			seg_q    <= '0;
			off_q    <= '0;
			tri_q    <= '0;
			shift_q  <= '0;
			held_q   <= '0;
			low_q    <= '0;
			high_q   <= '0;
			pec_q    <= '0;
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
			ack_q    <= 1'b0;
		end else if (step_en) begin
			active_q <= active_n;
			seg_q    <= seg_n;
			off_q    <= off_n;
			tri_q    <= tri_n;
			shift_q  <= shift_n;
			held_q   <= held_n;
			low_q    <= low_n;
			high_q   <= high_n;
			pec_q    <= pec_n;
			scl_q    <= scl_n;
			sda_q    <= sda_n;
			ack_q    <= ack_n;
		end
	end

	assign res.scl_out    = scl_n;
	assign res.sda_out    = sda_n;
	assign res.busy_res   = active_n;
	assign res.done_res   = done;
	assign res.read_word  = {high_n, low_n};
	assign res.pec_byte   = pec_n;
	assign res.ack_missed = ack_n;

endmodule

@@ design/i2c_master_read_word.sv @@
// I2C master that runs one SMBus read-word-with-PEC transaction, one pin action per
// input beat: each s beat is one bus tick (request flag, register byte, sampled SDA)
// and yields exactly one m beat with the SCL/SDA drive after that tick, busy/done
// status, the received word, the PEC byte and a sticky missed-ack flag. A request
// taken while idle starts a fixed 179-tick sequence (start, address+write, register
// byte, repeated start, address+read, low, high and PEC bytes, stop); requests while
// busy are ignored. One beat is taken per clock while m_tready does not stall the output;
// an s beat passes the input register and then the result register around the
// single-pass step logic on its way to its m beat. device_address may be written only while idle.
module i2c_master_read_word (
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,   // device_address
	// tick stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // start_req, reg_addr[7:0], sda_in, zero pad
	// result stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata      // scl_out, sda_out, busy_res, done_res,
	                                 // read_word[15:0], pec_byte[7:0], ack_missed, zero pad
);
	import i2cmrw_pkg::*;

	logic [6:0] dev_q;
	logic       valid_s1;
	item_t      item_s1;
	logic       adv;
	result_t    res;

	// a beat leaves the input register whenever the output register is free or draining
	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	// device address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q <= DEV_ADDR_RESET;
		end else if (cfg_we) begin
			dev_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.start_req <= s_tdata[0];
			item_s1.reg_addr  <= s_tdata[8:1];
			item_s1.sda_in    <= s_tdata[9];
		end
	end

	// sequencer: state advances once per beat leaving the input register
	i2cmrw_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (adv),
		.item     (item_s1),
		.dev_addr (dev_q),
		.res      (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {3'b000, res.ack_missed, res.pec_byte, res.read_word,
				res.done_res, res.busy_res, res.sda_out, res.scl_out};
		end
	end

endmodule

@@ design/i2cmrw_checker.sv @@
module i2cmrw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// with the output side empty the input side never back-pressures
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// the done beat ends the sequence with both lines released
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> !m_tdata[2] && m_tdata[0] && m_tdata[1])
		else $error("done beat with busy or lines held low");

	// a taken input beat passes the input and result registers to a result beat when output drains
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (!m_tvalid || m_tready) ##1 (!m_tvalid || m_tready)
		|=> m_tvalid)
		else $error("accepted beat lost");

endmodule

bind i2c_master_read_word i2cmrw_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
